>>> rtl/core/ftr_pkg.sv
// Shared types, constants and helpers for the filled triangle rasterizer.
`timescale 1ns / 1ps
package ftr_pkg;

  // Canvas store geometry
  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 64;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = COL_W + ROW_W;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

  // Datapath widths: Q16 x / slopes, Q4 y, multiplier b operand, divisor
  localparam int XW    = 48;
  localparam int YW    = 19;
  localparam int DW    = 36;
  localparam int DEN_W = 20;
  localparam int CNT_W = 14;

  // Request codes
  localparam logic REQ_FILL = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // Arithmetic unit operations
  localparam logic MDU_DIV = 1'b0;
  localparam logic MDU_MUL = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] vertex0_x;
    logic signed [15:0] vertex0_y;
    logic signed [15:0] vertex1_x;
    logic signed [15:0] vertex1_y;
    logic signed [15:0] vertex2_x;
    logic signed [15:0] vertex2_y;
    logic [7:0]         glyph;
    logic [6:0]         read_col;
    logic [5:0]         read_row;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       read_glyph;
    logic [CNT_W-1:0] cells_written;
  } out_item_t;

  typedef struct packed {
    logic go;
    logic op;
  } mdu_req_t;

  // ceil(v - 0.5) of a Q16 value
  function automatic logic signed [XW-1:0] ceil_half_q16(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] t;
    t = XW'(32768);
    t = t - v;
    t = t >>> 16;
    return -t;
  endfunction

  // ceil(v - 0.5) of a Q4 value
  function automatic logic signed [YW:0] ceil_half_q4(input logic signed [YW:0] v);
    logic signed [YW:0] t;
    t = (YW+1)'(8);
    t = t - v;
    t = t >>> 4;
    return -t;
  endfunction

endpackage

>>> rtl/core/ftr_mdu.sv
// Shared iterative multiply / divide unit, one bit per cycle.
`timescale 1ns / 1ps
module ftr_mdu import ftr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mdu_req_t             req,
  input  logic signed [XW-1:0] opa,
  input  logic signed [DW-1:0] opb,
  output logic                 done,
  output logic signed [XW-1:0] res
);

  localparam int PW   = XW + DW;
  localparam int CW   = $clog2(XW + 1);

  logic              busy_r;
  logic              op_r;
  logic              neg_r;
  logic [CW-1:0]     cnt_r;
  logic [PW-1:0]     acc_r;
  logic [XW-1:0]     mcand_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic              done_r;
  logic signed [XW-1:0] res_r;

  logic [XW-1:0]     a_mag;
  logic [DW-1:0]     b_mag;
  logic [XW:0]       sum;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    diff;
  logic [PW:0]       prod;
  logic [XW-1:0]     quo;

  // operand magnitudes
  assign a_mag = opa[XW-1] ? XW'(-opa) : XW'(opa);
  assign b_mag = opb[DW-1] ? DW'(-opb) : DW'(opb);

  // one shift-add or restoring-subtract step
  assign sum    = {1'b0, acc_r[PW-1:DW]} + (acc_r[0] ? {1'b0, mcand_r} : '0);
  assign rem_sh = {rem_r, acc_r[XW-1]};
  assign diff   = rem_sh - {1'b0, den_r};

  // sign fix of the final result
  assign prod = neg_r ? (PW+1)'(-{1'b0, acc_r}) : {1'b0, acc_r};
  assign quo  = neg_r ? XW'(-acc_r[XW-1:0]) : acc_r[XW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (req.go) begin
          busy_r  <= 1'b1;
          op_r    <= req.op;
          rem_r   <= '0;
          den_r   <= opb[DEN_W-1:0];
          mcand_r <= a_mag;
          if (req.op == MDU_MUL) begin
            neg_r <= opa[XW-1] ^ opb[DW-1];
            cnt_r <= CW'(DW);
            acc_r <= {{XW{1'b0}}, b_mag};
          end else begin
            neg_r <= opa[XW-1];
            cnt_r <= CW'(XW);
            acc_r <= {{DW{1'b0}}, a_mag};
          end
        end
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (op_r == MDU_MUL) begin
          acc_r <= {sum, acc_r[DW-1:1]};
        end else begin
          if (!diff[DEN_W]) begin
            rem_r <= diff[DEN_W-1:0];
          end else begin
            rem_r <= rem_sh[DEN_W-1:0];
          end
          acc_r[XW-1:0] <= {acc_r[XW-2:0], ~diff[DEN_W]};
        end
      end else begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
        res_r  <= (op_r == MDU_MUL) ? $signed(prod[XW+15:16]) : $signed(quo);
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

>>> rtl/core/filled_triangle_rasterizer.sv
// Top level: triangle fill sequencer, canvas store and configuration registers.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  request | start, busy, in_data                    | in
//  result  | out_valid, out_data                     | out
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// After reset the canvas is swept to zero, one cell a cycle, with busy high.
// A read passes through the READ and RDOUT states. A draw first finds the split point
// in the shared mul/div unit when no edge is flat, then the slopes and start x of each
// flat part that has rows, then walks the rows and writes each cell (one store write port).
// One item at a time; busy stays high until its result strobe.
// The result is held one cycle under out_valid; the receiver cannot stall it.
`timescale 1ns / 1ps
module filled_triangle_rasterizer import ftr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [7:0] cfg_data
);

  // sequencer states
  localparam logic [4:0] ST_CLEAR  = 5'd0;
  localparam logic [4:0] ST_IDLE   = 5'd1;
  localparam logic [4:0] ST_READ   = 5'd2;
  localparam logic [4:0] ST_RDOUT  = 5'd3;
  localparam logic [4:0] ST_SORT   = 5'd4;
  localparam logic [4:0] ST_ALPHA  = 5'd5;
  localparam logic [4:0] ST_VI     = 5'd6;
  localparam logic [4:0] ST_VSIDE  = 5'd7;
  localparam logic [4:0] ST_PART   = 5'd8;
  localparam logic [4:0] ST_SLP_L  = 5'd9;
  localparam logic [4:0] ST_SLP_R  = 5'd10;
  localparam logic [4:0] ST_X_L    = 5'd11;
  localparam logic [4:0] ST_X_R    = 5'd12;
  localparam logic [4:0] ST_ROW    = 5'd13;
  localparam logic [4:0] ST_COL    = 5'd14;
  localparam logic [4:0] ST_NEXT   = 5'd15;
  localparam logic [4:0] ST_DONE   = 5'd16;

  // triangle shapes
  localparam logic [1:0] KIND_ZERO  = 2'd0;
  localparam logic [1:0] KIND_FT    = 2'd1;
  localparam logic [1:0] KIND_FB    = 2'd2;
  localparam logic [1:0] KIND_SPLIT = 2'd3;

  // point ids: sorted vertices and the split point
  localparam logic [1:0] PT_0 = 2'd0;
  localparam logic [1:0] PT_1 = 2'd1;
  localparam logic [1:0] PT_2 = 2'd2;
  localparam logic [1:0] PT_V = 2'd3;

  logic [4:0]              state_r, state_nxt;
  logic [7:0]              width_r;
  logic [6:0]              height_r;
  logic signed [YW-1:0]    mx_r [3];
  logic signed [YW-1:0]    my_r [3];
  logic signed [XW-1:0]    px_r [3];
  logic signed [YW-1:0]    py_r [3];
  logic signed [XW-1:0]    vx_r;
  logic [7:0]              glyph_r;
  logic [1:0]              kind_r;
  logic                    part_r;
  logic                    vleft_r;
  logic signed [XW-1:0]    slope_l_r, slope_r_r;
  logic signed [XW-1:0]    xl_r, xr_r;
  logic [ROW_W:0]          row_r, rend_r;
  logic [COL_W:0]          col_r, cend_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [ADDR_W-1:0]       rd_addr_r;
  logic [ADDR_W-1:0]       clr_addr_r;
  logic                    issued_r;
  logic [7:0]              rdata_r;
  logic                    out_valid_r;
  out_item_t               out_data_r;
  logic [7:0]              mem [DEPTH];

  logic                    accept;
  logic [COL_W:0]          wlim;
  logic [ROW_W:0]          hlim;
  logic signed [YW-1:0]    hw, hh;
  logic signed [YW-1:0]    sx [3];
  logic signed [YW-1:0]    sy [3];
  logic signed [YW-1:0]    tmx, tmy;
  logic [1:0]              kind_c;
  logic [1:0]              id_top, id_bot, id_lo, id_le, id_ro, id_re, id_org, id_end;
  logic signed [XW-1:0]    ex_org, ex_end;
  logic signed [YW-1:0]    ey_org, ey_end, y_top, y_bot;
  logic signed [YW:0]      dy_e;
  logic signed [YW:0]      rs_w, re_w, rs_c, re_c;
  logic signed [XW-1:0]    cs_w, ce_w, cs_c, ce_c;
  logic                    r_side;
  logic                    slope_skip;
  mdu_req_t                mdu_req;
  logic                    mdu_op;
  logic signed [XW-1:0]    mdu_a;
  logic signed [DW-1:0]    mdu_b;
  logic                    mdu_done;
  logic signed [XW-1:0]    mdu_res;
  logic                    arith_st;
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr;
  logic [7:0]              mem_wdata;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // clip limits and centring offsets in Q4
  assign wlim = (width_r > 8'(MAX_WIDTH)) ? (COL_W+1)'(MAX_WIDTH) : (COL_W+1)'(width_r);
  assign hlim = (height_r > 7'(MAX_HEIGHT)) ? (ROW_W+1)'(MAX_HEIGHT) : (ROW_W+1)'(height_r);
  assign hw   = $signed(YW'({width_r[7:1], 4'b0}));
  assign hh   = $signed(YW'({height_r[6:1], 4'b0}));

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 8'd80;
      height_r <= 7'd40;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // sort by y, order the flat edge by x and classify the shape
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sx[i] = mx_r[i];
      sy[i] = my_r[i];
    end
    if (sy[1] < sy[0]) begin
      tmx = sx[0]; tmy = sy[0]; sx[0] = sx[1]; sy[0] = sy[1]; sx[1] = tmx; sy[1] = tmy;
    end
    if (sy[2] < sy[0]) begin
      tmx = sx[0]; tmy = sy[0]; sx[0] = sx[2]; sy[0] = sy[2]; sx[2] = tmx; sy[2] = tmy;
    end
    if (sy[2] < sy[1]) begin
      tmx = sx[1]; tmy = sy[1]; sx[1] = sx[2]; sy[1] = sy[2]; sx[2] = tmx; sy[2] = tmy;
    end
    tmx = '0;
    tmy = '0;
    if (sy[0] == sy[1]) begin
      if (sx[1] < sx[0]) begin
        tmx = sx[0]; sx[0] = sx[1]; sx[1] = tmx;
      end
      kind_c = (sy[2] > sy[0]) ? KIND_FT : KIND_ZERO;
    end else if (sy[1] == sy[2]) begin
      if (sx[2] < sx[1]) begin
        tmx = sx[1]; sx[1] = sx[2]; sx[2] = tmx;
      end
      kind_c = KIND_FB;
    end else begin
      kind_c = KIND_SPLIT;
    end
  end

  // edge endpoints of the current flat part
  always_comb begin
    id_top = PT_0; id_bot = PT_2;
    id_lo = PT_0; id_le = PT_2; id_ro = PT_1; id_re = PT_2;
    case (kind_r)
      KIND_FB: begin
        id_le = PT_1; id_ro = PT_0;
      end
      KIND_SPLIT: begin
        if (!part_r) begin
          id_bot = PT_1; id_lo = PT_0; id_ro = PT_0;
          id_le  = vleft_r ? PT_1 : PT_V;
          id_re  = vleft_r ? PT_V : PT_1;
        end else begin
          id_top = PT_1; id_le = PT_2; id_re = PT_2;
          id_lo  = vleft_r ? PT_1 : PT_V;
          id_ro  = vleft_r ? PT_V : PT_1;
        end
      end
      default: ;
    endcase
  end

  assign r_side = (state_r == ST_SLP_R) || (state_r == ST_X_R);
  assign id_org = r_side ? id_ro : id_lo;
  assign id_end = r_side ? id_re : id_le;
  assign ex_org = (id_org == PT_V) ? vx_r : px_r[id_org];
  assign ex_end = (id_end == PT_V) ? vx_r : px_r[id_end];
  assign ey_org = (id_org == PT_V) ? py_r[1] : py_r[id_org];
  assign ey_end = (id_end == PT_V) ? py_r[1] : py_r[id_end];
  assign y_top  = (id_top == PT_V) ? py_r[1] : py_r[id_top];
  assign y_bot  = (id_bot == PT_V) ? py_r[1] : py_r[id_bot];
  assign dy_e   = (YW+1)'(ey_end) - (YW+1)'(ey_org);
  assign slope_skip = (dy_e <= 0);

  // row span of the part, clipped
  assign rs_w = ceil_half_q4((YW+1)'(y_top));
  assign re_w = ceil_half_q4((YW+1)'(y_bot));
  assign rs_c = (rs_w < 0) ? '0 : rs_w;
  assign re_c = (re_w > $signed((YW+1)'(hlim))) ? $signed((YW+1)'(hlim)) : re_w;

  // column span of the current row, clipped
  assign cs_w = ceil_half_q16(xl_r);
  assign ce_w = ceil_half_q16(xr_r);
  assign cs_c = (cs_w < 0) ? '0 : cs_w;
  assign ce_c = (ce_w > $signed(XW'(wlim))) ? $signed(XW'(wlim)) : ce_w;

  // operands for the shared mul/div unit
  always_comb begin
    mdu_a = '0;
    mdu_b = '0;
    mdu_op = MDU_DIV;
    case (state_r)
      ST_ALPHA: begin
        mdu_a = XW'(py_r[1] - py_r[0]) <<< 16;
        mdu_b = DW'(py_r[2] - py_r[0]);
      end
      ST_VI: begin
        mdu_op = MDU_MUL;
        mdu_a = px_r[2] - px_r[0];
        mdu_b = DW'(slope_l_r);
      end
      ST_SLP_L, ST_SLP_R: begin
        mdu_a = (ex_end - ex_org) <<< 4;
        mdu_b = DW'(dy_e);
      end
      ST_X_L, ST_X_R: begin
        mdu_op = MDU_MUL;
        mdu_a = r_side ? slope_r_r : slope_l_r;
        mdu_b = $signed(DW'({row_r, 16'h8000})) - (DW'(ey_org) <<< 12);
      end
      default: ;
    endcase
  end

  assign arith_st = (state_r == ST_ALPHA) || (state_r == ST_VI) ||
                    (state_r == ST_X_L) || (state_r == ST_X_R) ||
                    (((state_r == ST_SLP_L) || (state_r == ST_SLP_R)) && !slope_skip);
  assign mdu_req = '{go: arith_st && !issued_r, op: mdu_op};

  ftr_mdu u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mdu_req),
    .opa   (mdu_a),
    .opb   (mdu_b),
    .done  (mdu_done),
    .res   (mdu_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_addr_r == ADDR_W'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept) state_nxt = (in_data.req_type == REQ_READ) ? ST_READ : ST_SORT;
      ST_READ:  state_nxt = ST_RDOUT;
      ST_RDOUT: state_nxt = ST_IDLE;
      ST_SORT: begin
        case (kind_c)
          KIND_ZERO:  state_nxt = ST_DONE;
          KIND_SPLIT: state_nxt = ST_ALPHA;
          default:    state_nxt = ST_PART;
        endcase
      end
      ST_ALPHA: if (mdu_done) state_nxt = ST_VI;
      ST_VI:    if (mdu_done) state_nxt = ST_VSIDE;
      ST_VSIDE: state_nxt = ST_PART;
      ST_PART: begin
        if (rs_c < re_c) state_nxt = ST_SLP_L;
        else if (!(kind_r == KIND_SPLIT && !part_r)) state_nxt = ST_DONE;
      end
      ST_SLP_L: if (slope_skip || mdu_done) state_nxt = ST_SLP_R;
      ST_SLP_R: if (slope_skip || mdu_done) state_nxt = ST_X_L;
      ST_X_L:   if (mdu_done) state_nxt = ST_X_R;
      ST_X_R:   if (mdu_done) state_nxt = ST_ROW;
      ST_ROW:   state_nxt = (cs_c < ce_c) ? ST_COL : ST_NEXT;
      ST_COL:   if (col_r + 1'b1 == cend_r) state_nxt = ST_NEXT;
      ST_NEXT: begin
        if (row_r + 1'b1 != rend_r) state_nxt = ST_ROW;
        else if (kind_r == KIND_SPLIT && !part_r) state_nxt = ST_PART;
        else state_nxt = ST_DONE;
      end
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_DONE) || (state_r == ST_RDOUT);
      if (state_r == ST_CLEAR) clr_addr_r <= clr_addr_r + 1'b1;
      if (mdu_req.go) issued_r <= 1'b1;
      else if (mdu_done) issued_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        rd_addr_r <= {in_data.read_row, in_data.read_col};
        glyph_r   <= in_data.glyph;
        cnt_r     <= '0;
        part_r    <= 1'b0;
        vleft_r   <= 1'b0;
        mx_r[0]   <= YW'(in_data.vertex0_x) + hw;
        my_r[0]   <= hh - YW'(in_data.vertex0_y);
        mx_r[1]   <= YW'(in_data.vertex1_x) + hw;
        my_r[1]   <= hh - YW'(in_data.vertex1_y);
        mx_r[2]   <= YW'(in_data.vertex2_x) + hw;
        my_r[2]   <= hh - YW'(in_data.vertex2_y);
      end
      ST_SORT: begin
        kind_r <= kind_c;
        for (int i = 0; i < 3; i++) begin
          px_r[i] <= XW'(sx[i]) <<< 12;
          py_r[i] <= sy[i];
        end
      end
      ST_ALPHA: if (mdu_done) slope_l_r <= mdu_res;
      ST_VI:    if (mdu_done) vx_r <= px_r[0] + mdu_res;
      ST_VSIDE: vleft_r <= (px_r[1] < vx_r);
      ST_PART: begin
        if (rs_c < re_c) begin
          row_r  <= (ROW_W+1)'(rs_c);
          rend_r <= (ROW_W+1)'(re_c);
        end else begin
          part_r <= 1'b1;
        end
      end
      ST_SLP_L: begin
        if (slope_skip) slope_l_r <= '0;
        else if (mdu_done) slope_l_r <= mdu_res;
      end
      ST_SLP_R: begin
        if (slope_skip) slope_r_r <= '0;
        else if (mdu_done) slope_r_r <= mdu_res;
      end
      ST_X_L: if (mdu_done) xl_r <= ex_org + mdu_res;
      ST_X_R: if (mdu_done) xr_r <= ex_org + mdu_res;
      ST_ROW: begin
        col_r  <= (COL_W+1)'(cs_c);
        cend_r <= (COL_W+1)'(ce_c);
      end
      ST_COL: begin
        col_r <= col_r + 1'b1;
        cnt_r <= cnt_r + 1'b1;
      end
      ST_NEXT: begin
        xl_r  <= xl_r + slope_l_r;
        xr_r  <= xr_r + slope_r_r;
        row_r <= row_r + 1'b1;
        if (row_r + 1'b1 == rend_r) part_r <= 1'b1;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == ST_RDOUT) begin
      out_data_r.read_glyph    <= rdata_r;
      out_data_r.cells_written <= '0;
    end else if (state_r == ST_DONE) begin
      out_data_r.read_glyph    <= '0;
      out_data_r.cells_written <= cnt_r;
    end
  end

  // canvas store: one write port, registered read
  assign mem_we    = (state_r == ST_CLEAR) || (state_r == ST_COL);
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_addr_r :
                     {row_r[ROW_W-1:0], col_r[COL_W-1:0]};
  assign mem_wdata = (state_r == ST_CLEAR) ? 8'd0 : glyph_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[rd_addr_r];
  end

  // checks
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without a busy item");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held two cycles");
  a_col_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_COL |-> col_r < cend_r) else $error("cell write past span end");
  a_mdu_owned: assert property (@(posedge clk) disable iff (!rst_n)
    mdu_done |-> issued_r) else $error("mul/div result nobody asked for");

endmodule
